// ===== sv/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg
// Shared constants and types of the postfix stack evaluator: default sizes,
// operation and status codes, saturation limits, divider request/response.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

	// default sizes
	localparam int STACK_DEPTH_DEF = 64;
	localparam int FRAC_BITS_DEF   = 16;

	// operation codes
	localparam logic [2:0] FUNC_PUSH  = 3'd0;
	localparam logic [2:0] FUNC_ADD   = 3'd1;
	localparam logic [2:0] FUNC_SUB   = 3'd2;
	localparam logic [2:0] FUNC_MUL   = 3'd3;
	localparam logic [2:0] FUNC_DIV   = 3'd4;
	localparam logic [2:0] FUNC_CLEAR = 3'd5;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_UNDER = 2'd1;
	localparam logic [1:0] STAT_OVER  = 2'd2;
	localparam logic [1:0] STAT_DIVZ  = 2'd3;

	// saturation limits of a 32-bit word
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	// divider request: start pulse with left (dividend) and right (divisor)
	typedef struct packed {
		logic               start;
		logic signed [31:0] l;
		logic signed [31:0] r;
	} div_req_t;

	// divider response: done holds until the next start
	typedef struct packed {
		logic               done;
		logic signed [31:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/pse_ifs.sv =====
// ----------------------------------------------------------------------------
// pse_ifs
// Valid/ready channels of the evaluator: command word in, result word out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pse_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic signed [31:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

interface pse_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] top_value;
	logic [6:0]         stack_depth;
	logic [1:0]         status;

	modport source (output valid, output top_value, output stack_depth, output status,
		input ready);
	modport sink   (input valid, input top_value, input stack_depth, input status,
		output ready);
endinterface

`default_nettype wire

// ===== sv/pse_stack_mem.sv =====
// ----------------------------------------------------------------------------
// pse_stack_mem
// Stack entries below the top: one write port, one read port, registered
// read data. Contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_stack_mem #(
	parameter int DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int AW    = $clog2(pse_pkg::STACK_DEPTH_DEF)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/pse_divider.sv =====
// ----------------------------------------------------------------------------
// pse_divider
// Iterative restoring divider for (l * 2^FRAC_BITS) / r, one quotient bit a
// cycle on magnitudes, truncated toward zero, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_divider #(
	parameter int FRAC_BITS = pse_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pse_pkg::div_req_t req,
	output pse_pkg::div_rsp_t      rsp
);
	import pse_pkg::*;

	localparam int NW   = 32 + FRAC_BITS;
	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   num_q;
	logic [31:0]     rem_q;
	logic [31:0]     den_q;
	logic            neg_q;

	logic [31:0] l_mag;
	logic [31:0] r_mag;
	logic [32:0] shifted;
	logic [32:0] diffv;
	logic        ge;

	// operand magnitudes
	assign l_mag = req.l[31] ? 32'(-req.l) : 32'(req.l);
	assign r_mag = req.r[31] ? 32'(-req.r) : 32'(req.r);

	// one restoring step
	assign shifted = {rem_q, num_q[NW-1]};
	assign diffv   = shifted - {1'b0, den_q};
	assign ge      = (shifted >= {1'b0, den_q});

	// control: run for NW steps, then hold done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNTW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: shift quotient bits into the dividend register
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= NW'(l_mag) << FRAC_BITS;
			den_q <= r_mag;
			rem_q <= '0;
			neg_q <= req.l[31] ^ req.r[31];
		end else if (busy_q) begin
			rem_q <= ge ? diffv[31:0] : shifted[31:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	// sign and saturate the held quotient
	always_comb begin
		rsp.done = done_q;
		if (neg_q) begin
			if (num_q > (NW'(1) << 31)) begin
				rsp.quot = signed'(Q_MIN);
			end else begin
				rsp.quot = signed'(32'(-num_q[31:0]));
			end
		end else begin
			if (num_q > NW'(Q_MAX)) begin
				rsp.quot = signed'(Q_MAX);
			end else begin
				rsp.quot = signed'(num_q[31:0]);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/postfix_stack_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit
// Postfix evaluator on an operand stack of signed fixed-point words.
// Push, clear, add, subtract, underflow and overflow finish from the execute state;
// multiply adds a registered product state; a nonzero divide waits in a divide state
// for the one-bit-a-cycle divider (Q16.16 words by default).
// One word is in flight at a time; a new word is taken while the result waits.
// Reset clears the depth to zero; stack memory contents stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator_unit #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int FRAC_BITS   = pse_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pse_req_if.sink  req,
	pse_rsp_if.source rsp
);
	import pse_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam logic signed [63:0] S64_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S64_MIN = -64'sd2147483648;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MUL, S_DIV} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] top_q;
	logic [2:0]         func_q;
	logic signed [31:0] val_q;
	logic signed [63:0] prod_s1;
	logic               rsp_valid_q;
	logic signed [31:0] rsp_top_q;
	logic [6:0]         rsp_depth_q;
	logic [1:0]         rsp_stat_q;

	logic [31:0]        rdata;
	logic signed [31:0] l_val;
	logic               mem_re;
	logic               mem_we;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               free;
	logic               fin;
	logic               fire;
	logic               go_mul;
	logic               go_div;
	logic signed [31:0] new_top;
	logic [CW-1:0]      new_count;
	logic [1:0]         new_stat;
	logic signed [32:0] sum;
	logic signed [32:0] diff;
	logic signed [63:0] prod_sh;
	logic signed [31:0] sum_sat;
	logic signed [31:0] diff_sat;
	logic signed [31:0] prod_sat;
	logic               under;

	// stack entries below the cached top
	pse_stack_mem #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(AW'(count_q - CW'(1))),
		.wdata(top_q),
		.re   (mem_re),
		.raddr(AW'(count_q - CW'(2))),
		.rdata(rdata)
	);

	pse_divider #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// handshake
	assign req.ready = (state_q == S_IDLE);
	assign mem_re    = req.valid && (state_q == S_IDLE);
	assign free      = !rsp_valid_q || rsp.ready;
	assign fire      = fin && free;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.top_value   = rsp_top_q;
	assign rsp.stack_depth = rsp_depth_q;
	assign rsp.status      = rsp_stat_q;

	// arithmetic on left (memory) and right (cached top)
	assign l_val   = signed'(rdata);
	assign sum     = {l_val[31], l_val} + {top_q[31], top_q};
	assign diff    = {l_val[31], l_val} - {top_q[31], top_q};
	assign prod_sh = prod_s1 >>> FRAC_BITS;
	assign under   = (count_q < CW'(2));

	always_comb begin
		if (sum > 33'sd2147483647) begin
			sum_sat = signed'(Q_MAX);
		end else if (sum < -33'sd2147483648) begin
			sum_sat = signed'(Q_MIN);
		end else begin
			sum_sat = sum[31:0];
		end
		if (diff > 33'sd2147483647) begin
			diff_sat = signed'(Q_MAX);
		end else if (diff < -33'sd2147483648) begin
			diff_sat = signed'(Q_MIN);
		end else begin
			diff_sat = diff[31:0];
		end
		if (prod_sh > S64_MAX) begin
			prod_sat = signed'(Q_MAX);
		end else if (prod_sh < S64_MIN) begin
			prod_sat = signed'(Q_MIN);
		end else begin
			prod_sat = prod_sh[31:0];
		end
	end

	// decide the step outcome
	always_comb begin
		fin         = 1'b0;
		go_mul      = 1'b0;
		go_div      = 1'b0;
		mem_we      = 1'b0;
		new_top     = top_q;
		new_count   = count_q;
		new_stat    = STAT_OK;
		div_req     = '0;
		div_req.l   = l_val;
		div_req.r   = top_q;
		case (state_q)
			S_EXEC: begin
				case (func_q)
					FUNC_PUSH: begin
						fin = 1'b1;
						if (count_q >= CW'(STACK_DEPTH)) begin
							new_stat = STAT_OVER;
						end else begin
							mem_we    = free && (count_q != '0);
							new_top   = val_q;
							new_count = count_q + CW'(1);
						end
					end
					FUNC_ADD, FUNC_SUB: begin
						fin = 1'b1;
						if (under) begin
							new_stat = STAT_UNDER;
						end else begin
							new_top   = (func_q == FUNC_ADD) ? sum_sat : diff_sat;
							new_count = count_q - CW'(1);
						end
					end
					FUNC_MUL: begin
						if (under) begin
							fin      = 1'b1;
							new_stat = STAT_UNDER;
						end else begin
							go_mul = 1'b1;
						end
					end
					FUNC_DIV: begin
						if (under) begin
							fin      = 1'b1;
							new_stat = STAT_UNDER;
						end else if (top_q == '0) begin
							fin       = 1'b1;
							new_stat  = STAT_DIVZ;
							new_top   = l_val[31] ? signed'(Q_MIN) : signed'(Q_MAX);
							new_count = count_q - CW'(1);
						end else begin
							go_div        = 1'b1;
							div_req.start = 1'b1;
						end
					end
					FUNC_CLEAR: begin
						fin       = 1'b1;
						new_count = '0;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_MUL: begin
				fin       = 1'b1;
				new_top   = prod_sat;
				new_count = count_q - CW'(1);
			end
			S_DIV: begin
				fin       = div_rsp.done;
				new_top   = div_rsp.quot;
				new_count = count_q - CW'(1);
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// hold state, depth and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (fire) begin
				count_q <= new_count;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go_mul) begin
						state_q <= S_MUL;
					end else if (go_div) begin
						state_q <= S_DIV;
					end else if (fire) begin
						state_q <= S_IDLE;
					end
				end
				S_MUL, S_DIV: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// capture the word, product, top and result payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q <= req.func;
			val_q  <= req.value;
		end
		if (go_mul) begin
			prod_s1 <= 64'(l_val) * 64'(top_q);
		end
		if (fire) begin
			top_q       <= new_top;
			rsp_top_q   <= (new_count == '0) ? '0 : new_top;
			rsp_depth_q <= 7'(new_count);
			rsp_stat_q  <= new_stat;
		end
	end

endmodule

`default_nettype wire
